[sv/stereo_polyphase_fir_resampler_defines.svh]
// Assertion macros used by the checker file of the stereo resampler.
`ifndef STEREO_POLYPHASE_FIR_RESAMPLER_DEFINES_SVH
`define STEREO_POLYPHASE_FIR_RESAMPLER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, quiet while in reset.
`define SPFR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, quiet while in reset.
`define SPFR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/spfr_pkg.sv]
// Package with the types and constants of the stereo polyphase resampler.
`default_nettype none

package spfr_pkg;

	// Default sizes of the filter.
	localparam int SPFR_TAPS       = 16;
	localparam int SPFR_MAX_PHASES = 64;

	// Fixed field widths.
	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 18;
	localparam int COEF_IDX_W = 10;
	localparam int PROD_W     = SAMPLE_W + COEF_W;
	localparam int PCOUNT_W   = 7;
	localparam int CNT_W      = 9;

	// Configuration port.
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 32;

	// Action codes of an input transaction.
	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_READ  = 2'd1,
		ACT_LOAD  = 2'd2
	} action_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN
	} state_t;

	// Control from the sequencer to the multiply-accumulate unit.
	typedef struct packed {
		logic clear;
		logic valid;
	} mac_ctl_t;

endpackage

`default_nettype wire

[sv/spfr_if.sv]
// Handshake interfaces for the input and result channels of the resampler.
`default_nettype none

interface spfr_item_if import spfr_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [1:0]                 action;
	logic signed [SAMPLE_W-1:0] left_sample;
	logic signed [SAMPLE_W-1:0] right_sample;
	logic [COEF_IDX_W-1:0]      coef_index;
	logic signed [COEF_W-1:0]   coef_value;

	modport source (output valid, action, left_sample, right_sample, coef_index, coef_value,
		input ready);
	modport sink (input valid, action, left_sample, right_sample, coef_index, coef_value,
		output ready);
endinterface

interface spfr_result_if import spfr_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] left_out;
	logic signed [SAMPLE_W-1:0] right_out;

	modport source (output valid, left_out, right_out, input ready);
	modport sink (input valid, left_out, right_out, output ready);
endinterface

`default_nettype wire

[sv/spfr_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module spfr_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 1024
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

endmodule

`default_nettype wire

[sv/spfr_mac.sv]
// Stereo multiply-accumulate unit, one tap of both channels per cycle.
`default_nettype none

module spfr_mac import spfr_pkg::*; #(
	parameter int ACC_W = PROD_W + 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire mac_ctl_t                   ctl,
	input  wire logic signed [COEF_W-1:0]   coef,
	input  wire logic signed [SAMPLE_W-1:0] left_sample,
	input  wire logic signed [SAMPLE_W-1:0] right_sample,
	output logic signed [ACC_W-1:0]         acc_left,
	output logic signed [ACC_W-1:0]         acc_right,
	output logic                            busy
);

	logic signed [PROD_W-1:0] prod_left_s2;
	logic signed [PROD_W-1:0] prod_right_s2;
	logic                     valid_s2;
	logic signed [ACC_W-1:0]  acc_left_q;
	logic signed [ACC_W-1:0]  acc_right_q;

	// Product stage: one coefficient times both channel samples.
	always_ff @(posedge clk) begin
		prod_left_s2  <= coef * left_sample;
		prod_right_s2 <= coef * right_sample;
	end

	// Accumulate stage, cleared when a new read starts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			acc_left_q  <= '0;
			acc_right_q <= '0;
		end else begin
			valid_s2 <= ctl.valid;
			if (ctl.clear) begin
				acc_left_q  <= '0;
				acc_right_q <= '0;
			end else if (valid_s2) begin
				acc_left_q  <= acc_left_q + ACC_W'(prod_left_s2);
				acc_right_q <= acc_right_q + ACC_W'(prod_right_s2);
			end
		end
	end

	assign acc_left  = acc_left_q;
	assign acc_right = acc_right_q;
	assign busy      = valid_s2;

endmodule

`default_nettype wire

[sv/stereo_polyphase_fir_resampler.sv]
// Top level of the stereo polyphase FIR resampler core.
`default_nettype none

// A write transaction stores one left/right frame in a circular line of TAPS frames, and a load
// transaction writes one coefficient word into the coefficient RAM. A read transaction forms
// the dot product of the current phase's TAPS coefficients with the stored frames, newest frame
// on tap 0, using one stereo multiply-accumulate unit that handles one tap per cycle: the input
// is not ready after a read is accepted until all TAPS coefficients have gone through the
// coefficient RAM read port and the RAM and multiplier pipeline has drained, and longer if the
// previous result has not been taken yet. The sum is rounded to Q1.15, ties up, and saturated.
// The phase pointer advances when a read is accepted and wraps after phase_count phases (0
// counts as 1, values above MAX_PHASES as MAX_PHASES). The coefficient RAM is not cleared after
// reset; every entry of a phase in use must be loaded before it is read. Coefficient indices at
// or beyond TAPS * MAX_PHASES are ignored, as is action code 3.
module stereo_polyphase_fir_resampler import spfr_pkg::*; #(
	parameter int TAPS       = SPFR_TAPS,
	parameter int MAX_PHASES = SPFR_MAX_PHASES
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	spfr_item_if.sink                  item,
	spfr_result_if.source              result,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic      [CFG_DATA_W-1:0] prdata,
	output logic                       pready
);

	localparam int SLOT_W = $clog2(TAPS);
	localparam int PTR_W  = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
	localparam int DEPTH  = TAPS * MAX_PHASES;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int ACC_W  = PROD_W + $clog2(TAPS);
	localparam logic [SLOT_W-1:0] TAP_LAST = SLOT_W'(TAPS - 1);
	localparam logic [CFG_ADDR_W-1:0] REG_PHASE_COUNT = '0;

	state_t state_q, state_d;

	logic [PCOUNT_W-1:0] phase_count_q;
	logic [SLOT_W-1:0]   write_slot_q;
	logic [PTR_W-1:0]    phase_ptr_q;
	logic [SLOT_W-1:0]   tap_q;
	logic [SLOT_W-1:0]   rd_slot_q;
	logic [ADDR_W-1:0]   addr_q;
	logic                valid_s1;
	logic                out_valid_q;

	logic signed [SAMPLE_W-1:0] hist_left_q  [TAPS];
	logic signed [SAMPLE_W-1:0] hist_right_q [TAPS];
	logic signed [SAMPLE_W-1:0] left_s1;
	logic signed [SAMPLE_W-1:0] right_s1;
	logic signed [SAMPLE_W-1:0] out_left_q;
	logic signed [SAMPLE_W-1:0] out_right_q;

	logic                accept;
	logic                issue;
	logic                finish;
	logic                out_free;
	logic                coef_we;
	logic [CNT_W-1:0]    eff_count;
	logic [CNT_W-1:0]    ptr_next;
	logic [COEF_W-1:0]   coef_rdata;
	mac_ctl_t            mac_ctl;
	logic                mac_busy;
	logic signed [ACC_W-1:0] acc_left;
	logic signed [ACC_W-1:0] acc_right;

	// Round a Q7.31 sum to Q1.15 with ties up, then saturate to 16 bits.
	function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W:0]    t;
		logic signed [ACC_W-16:0] q;
		logic signed [SAMPLE_W-1:0] r;
		t = (ACC_W + 1)'(a) + (ACC_W + 1)'(32768);
		q = t[ACC_W:16];
		if (q > (ACC_W - 15)'(32767)) begin
			r = 16'sh7fff;
		end else if (q < -(ACC_W - 15)'(32768)) begin
			r = 16'sh8000;
		end else begin
			r = q[SAMPLE_W-1:0];
		end
		return r;
	endfunction

	// Configuration register: every write lands in phase_count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_count_q <= PCOUNT_W'(1);
		end else if (psel && penable && pwrite) begin
			phase_count_q <= pwdata[PCOUNT_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == REG_PHASE_COUNT) ?
		{{(CFG_DATA_W - PCOUNT_W){1'b0}}, phase_count_q} : '0;

	// Effective phase count and the pointer after a read.
	always_comb begin
		if (phase_count_q == '0) begin
			eff_count = CNT_W'(1);
		end else if (CNT_W'(phase_count_q) > CNT_W'(MAX_PHASES)) begin
			eff_count = CNT_W'(MAX_PHASES);
		end else begin
			eff_count = CNT_W'(phase_count_q);
		end
		ptr_next = CNT_W'(phase_ptr_q) + CNT_W'(1);
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign out_free = !out_valid_q || result.ready;

	// Next state and sequencer outputs.
	always_comb begin
		state_d    = state_q;
		item.ready = 1'b0;
		issue      = 1'b0;
		finish     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid && item.action == ACT_READ) begin
					state_d = ST_MAC;
				end
			end
			ST_MAC: begin
				issue = 1'b1;
				if (tap_q == TAP_LAST) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!valid_s1 && !mac_busy && out_free) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign accept  = item.valid && item.ready;
	assign coef_we = accept && item.action == ACT_LOAD && 32'(item.coef_index) < DEPTH;

	// Frame history, write slot, phase pointer and read walk counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				hist_left_q[i]  <= '0;
				hist_right_q[i] <= '0;
			end
			write_slot_q <= '0;
			phase_ptr_q  <= '0;
			tap_q        <= '0;
			rd_slot_q    <= '0;
			addr_q       <= '0;
			valid_s1     <= 1'b0;
		end else begin
			valid_s1 <= issue;
			if (accept && item.action == ACT_WRITE) begin
				hist_left_q[write_slot_q]  <= item.left_sample;
				hist_right_q[write_slot_q] <= item.right_sample;
				write_slot_q <= (write_slot_q == TAP_LAST) ? '0 : write_slot_q + 1'b1;
			end
			if (accept && item.action == ACT_READ) begin
				tap_q     <= '0;
				addr_q    <= ADDR_W'(phase_ptr_q) * ADDR_W'(TAPS);
				rd_slot_q <= (write_slot_q == '0) ? TAP_LAST : write_slot_q - 1'b1;
				phase_ptr_q <= (ptr_next >= eff_count) ? '0 : ptr_next[PTR_W-1:0];
			end
			if (issue) begin
				tap_q     <= tap_q + 1'b1;
				addr_q    <= addr_q + 1'b1;
				rd_slot_q <= (rd_slot_q == '0) ? TAP_LAST : rd_slot_q - 1'b1;
			end
		end
	end

	// History samples registered alongside the coefficient read.
	always_ff @(posedge clk) begin
		left_s1  <= hist_left_q[rd_slot_q];
		right_s1 <= hist_right_q[rd_slot_q];
	end

	spfr_ram #(
		.WIDTH (COEF_W),
		.DEPTH (DEPTH)
	) u_coef_ram (
		.clk     (clk),
		.we      (coef_we),
		.waddr   (ADDR_W'(item.coef_index)),
		.wdata   (item.coef_value),
		.raddr   (addr_q),
		.rdata_q (coef_rdata)
	);

	assign mac_ctl.clear = accept && item.action == ACT_READ;
	assign mac_ctl.valid = valid_s1;

	spfr_mac #(
		.ACC_W (ACC_W)
	) u_mac (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (mac_ctl),
		.coef         ($signed(coef_rdata)),
		.left_sample  (left_s1),
		.right_sample (right_s1),
		.acc_left     (acc_left),
		.acc_right    (acc_right),
		.busy         (mac_busy)
	);

	// Result register; a finished read waits here until the transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_left_q  <= round_sat(acc_left);
			out_right_q <= round_sat(acc_right);
		end
	end

	assign result.valid     = out_valid_q;
	assign result.left_out  = out_left_q;
	assign result.right_out = out_right_q;

endmodule

`default_nettype wire

[sv/spfr_checker.sv]
// Port-level checker of the resampler and its bind to the top level.
`default_nettype none
`include "stereo_polyphase_fir_resampler_defines.svh"

module spfr_checker import spfr_pkg::*; (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       item_valid,
	input wire logic                       item_ready,
	input wire logic [1:0]                 item_action,
	input wire logic                       result_valid,
	input wire logic                       result_ready,
	input wire logic signed [SAMPLE_W-1:0] result_left,
	input wire logic signed [SAMPLE_W-1:0] result_right
);

	// A read occupies the multiply-accumulate sequence, so the next cycle cannot accept.
	`SPFR_ASSERT_NEXT(a_read_busy, item_valid && item_ready && item_action == ACT_READ, !item_ready, "read accepted but input still ready")
	// Writes, loads and ignored codes leave the input ready in the next cycle.
	`SPFR_ASSERT_NEXT(a_short_ready, item_valid && item_ready && item_action != ACT_READ, item_ready, "input not ready after single-cycle transaction")
	// A pending result stays offered.
	`SPFR_ASSERT_NEXT(a_out_hold, result_valid && !result_ready, result_valid, "result dropped before transaction")
	// A stalled result keeps its value.
	`SPFR_ASSERT_NEXT(a_out_stable, result_valid && !result_ready, $stable(result_left) && $stable(result_right), "stalled result changed")

endmodule

bind stereo_polyphase_fir_resampler spfr_checker u_spfr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.item_action  (item.action),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_left  (result.left_out),
	.result_right (result.right_out)
);

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for the stereo polyphase FIR resampler core.
`timescale 1ns / 100ps
`default_nettype none

module tb;
	import spfr_pkg::*;

	localparam int TAPS_N        = SPFR_TAPS;
	localparam int PHASES_N      = SPFR_MAX_PHASES;
	localparam int COEF_SLOTS    = TAPS_N * PHASES_N;
	localparam int SLOT_W        = $clog2(TAPS_N);
	localparam int SETTLE_CYCLES = TAPS_N + 8;
	localparam int CYCLE_LIMIT   = 400_000;
	localparam int SETTING_COUNT = 7;

	// Action code that the core ignores.
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// Register map of the configuration port.
	localparam logic [CFG_ADDR_W-1:0] REG_PHASE_COUNT = '0;

	// Extremes of the Q1.15 and Q2.16 formats.
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
	localparam logic signed [COEF_W-1:0]   COEF_MAX   = 18'sh1ffff;
	localparam logic signed [COEF_W-1:0]   COEF_MIN   = 18'sh20000;
	localparam longint                     SUM_LIMIT  = longint'(1) << 31;

	typedef struct packed {
		logic [1:0]                 act;
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic [COEF_IDX_W-1:0]      idx;
		logic signed [COEF_W-1:0]   coef;
	} action_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
	} frame_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	spfr_item_if   item_bus ();
	spfr_result_if result_bus ();

	stereo_polyphase_fir_resampler i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_bus),
		.result  (result_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Stimulus waiting to be sent and filtered frames still owed by the core.
	action_item_t pending_actions[$];
	frame_t       expected_frames[$];

	// Predicted state of the core.
	logic [PCOUNT_W-1:0]        cfg_phase_count;
	logic signed [SAMPLE_W-1:0] hist_left  [TAPS_N];
	logic signed [SAMPLE_W-1:0] hist_right [TAPS_N];
	logic signed [COEF_W-1:0]   coef_mem   [COEF_SLOTS];
	logic [SLOT_W-1:0]          next_slot;
	logic [5:0]                 phase_ptr;

	// Planning state: which coefficients are loaded and where the phase pointer will be.
	bit                         coef_loaded [COEF_SLOTS];
	logic [5:0]                 plan_phase;

	int  fail_count;
	int  cycle_count;
	int  writes_seen, reads_seen, loads_seen, ignored_seen, frames_checked, settings_used;
	int  send_gap, take_wait;
	bit  send_burst, take_burst;

	always #1 clk = ~clk;

	// Phase count in force: zero counts as one, large values are clipped.
	function automatic int active_phases(input logic [PCOUNT_W-1:0] pc);
		if (pc == 0)
			return 1;
		if (int'(pc) > PHASES_N)
			return PHASES_N;
		return int'(pc);
	endfunction

	function automatic logic [5:0] next_phase(input logic [5:0] ptr, input logic [PCOUNT_W-1:0] pc);
		if (int'(ptr) + 1 >= active_phases(pc))
			return '0;
		return ptr + 6'd1;
	endfunction

	// Round a Q7.31 sum to Q1.15, ties toward plus infinity, and saturate.
	function automatic logic signed [SAMPLE_W-1:0] round_q15(input longint acc);
		longint biased;
		biased = acc + 32768;
		if (biased >= SUM_LIMIT)
			return SAMPLE_MAX;
		if (biased < -SUM_LIMIT)
			return SAMPLE_MIN;
		return SAMPLE_W'(biased >>> 16);
	endfunction

	// Update the predicted state with one accepted transaction.
	function automatic void apply_action(input action_item_t it);
		longint             acc_left, acc_right;
		logic [SLOT_W-1:0]  newest, slot;
		int                 base;
		frame_t             res;
		case (it.act)
			ACT_WRITE: begin
				hist_left[next_slot]  = it.left;
				hist_right[next_slot] = it.right;
				next_slot             = next_slot + 1'b1;
				writes_seen++;
			end
			ACT_LOAD: begin
				coef_mem[it.idx] = it.coef;
				loads_seen++;
			end
			ACT_READ: begin
				acc_left  = 0;
				acc_right = 0;
				newest    = next_slot - 1'b1;
				base      = int'(phase_ptr) * TAPS_N;
				// Tap k weights the frame k steps older than the newest one.
				for (int k = 0; k < TAPS_N; k++) begin
					slot      = newest - SLOT_W'(k);
					acc_left  += longint'(coef_mem[base + k]) * longint'(hist_left[slot]);
					acc_right += longint'(coef_mem[base + k]) * longint'(hist_right[slot]);
				end
				phase_ptr = next_phase(phase_ptr, cfg_phase_count);
				res.left  = round_q15(acc_left);
				res.right = round_q15(acc_right);
				expected_frames.push_back(res);
				reads_seen++;
			end
			default: ignored_seen++;
		endcase
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// Mostly small coefficients so that many sums stay clear of saturation.
	function automatic logic signed [COEF_W-1:0] rand_coef();
		case ($urandom_range(0, 9))
			0: return COEF_MAX;
			1: return COEF_MIN;
			2, 3: return COEF_W'($urandom);
			4, 5, 6: return COEF_W'(int'($urandom_range(0, 16383)) - 8192);
			default: return COEF_W'(int'($urandom_range(0, 127)) - 64);
		endcase
	endfunction

	function automatic int draw_wait(input bit burst);
		return burst ? 0 : int'($urandom_range(0, 8));
	endfunction

	// Queue one transaction. A read is preceded by loads of any coefficient of its phase
	// that has not been written yet, so no undefined table entry is ever read.
	function automatic void queue_item(input logic [1:0] act,
			input logic signed [SAMPLE_W-1:0] left, input logic signed [SAMPLE_W-1:0] right,
			input logic [COEF_IDX_W-1:0] idx, input logic signed [COEF_W-1:0] coef);
		action_item_t it;
		int           pos;
		if (act == ACT_READ) begin
			for (int k = 0; k < TAPS_N; k++) begin
				pos = int'(plan_phase) * TAPS_N + k;
				if (!coef_loaded[pos])
					queue_item(ACT_LOAD, rand_sample(), rand_sample(), COEF_IDX_W'(pos),
						rand_coef());
			end
			plan_phase = next_phase(plan_phase, cfg_phase_count);
		end else if (act == ACT_LOAD) begin
			coef_loaded[idx] = 1'b1;
		end
		it = '{act, left, right, idx, coef};
		pending_actions.push_back(it);
	endfunction

	// Write the phase count through the configuration port and read it back.
	task automatic write_phase_count(input logic [PCOUNT_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_PHASE_COUNT;
		pwdata  <= CFG_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		cfg_phase_count = value;
		settings_used++;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== CFG_DATA_W'(value)) begin
			$error("phase_count: expected %0d, actual %0d", value, prdata);
			fail_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Wait until every queued transaction is accepted and every frame has come back.
	// The check runs on the falling edge, after the driver's updates at the rising edge.
	task automatic settle();
		@(negedge clk);
		while (pending_actions.size() != 0 || item_bus.valid || expected_frames.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Input driver: one transaction per pending item, with random gaps in between.
	always @(posedge clk or negedge arst_n) begin : item_driver
		action_item_t nxt;
		if (!arst_n) begin
			item_bus.valid        <= 1'b0;
			item_bus.action       <= ACT_WRITE;
			item_bus.left_sample  <= '0;
			item_bus.right_sample <= '0;
			item_bus.coef_index   <= '0;
			item_bus.coef_value   <= '0;
			send_gap              <= 0;
		end else begin
			if (item_bus.valid && item_bus.ready)
				apply_action('{item_bus.action, item_bus.left_sample, item_bus.right_sample,
					item_bus.coef_index, item_bus.coef_value});
			if (!item_bus.valid || item_bus.ready) begin
				if (send_gap != 0) begin
					item_bus.valid <= 1'b0;
					send_gap       <= send_gap - 1;
				end else if (pending_actions.size() != 0) begin
					nxt = pending_actions.pop_front();
					item_bus.valid        <= 1'b1;
					item_bus.action       <= nxt.act;
					item_bus.left_sample  <= nxt.left;
					item_bus.right_sample <= nxt.right;
					item_bus.coef_index   <= nxt.idx;
					item_bus.coef_value   <= nxt.coef;
					if ($urandom_range(0, 39) == 0)
						send_burst = !send_burst;
					send_gap <= draw_wait(send_burst);
				end else begin
					item_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compares each frame with the oldest expected one and stalls at random.
	always @(posedge clk or negedge arst_n) begin : frame_monitor
		frame_t want;
		int     pause;
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
			take_wait        <= 0;
		end else begin
			if (result_bus.valid && result_bus.ready) begin
				if (expected_frames.size() == 0) begin
					$error("unexpected frame: left_out %0d, right_out %0d",
						result_bus.left_out, result_bus.right_out);
					fail_count++;
				end else begin
					want = expected_frames.pop_front();
					frames_checked++;
					if (result_bus.left_out !== want.left) begin
						$error("left_out: expected %0d, actual %0d", want.left,
							result_bus.left_out);
						fail_count++;
					end
					if (result_bus.right_out !== want.right) begin
						$error("right_out: expected %0d, actual %0d", want.right,
							result_bus.right_out);
						fail_count++;
					end
				end
				if ($urandom_range(0, 39) == 0)
					take_burst = !take_burst;
				pause = draw_wait(take_burst);
				take_wait        <= pause;
				result_bus.ready <= (pause == 0);
			end else if (take_wait != 0) begin
				// The stall only counts down while a frame is being offered.
				if (result_bus.valid) begin
					take_wait        <= take_wait - 1;
					result_bus.ready <= (take_wait == 1);
				end
			end else begin
				result_bus.ready <= 1'b1;
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$error("timeout after %0d cycles, %0d frames outstanding", cycle_count,
				expected_frames.size());
			$display("Verification failed");
			$finish;
		end
	end

	// Reset, then a directed part and a series of random parts, each under its own phase count.
	initial begin
		logic [PCOUNT_W-1:0] setting;
		int                  budget;
		int                  made;
		int                  pick;
		int                  budgets [SETTING_COUNT];
		budgets = '{250, 120, 120, 80, 100, 150, 130};

		clk                   = 1'b0;
		arst_n                = 1'b0;
		psel                  = 1'b0;
		penable               = 1'b0;
		pwrite                = 1'b0;
		paddr                 = '0;
		pwdata                = '0;
		item_bus.valid        = 1'b0;
		item_bus.action       = ACT_WRITE;
		item_bus.left_sample  = '0;
		item_bus.right_sample = '0;
		item_bus.coef_index   = '0;
		item_bus.coef_value   = '0;
		result_bus.ready      = 1'b0;
		fail_count            = 0;
		cycle_count           = 0;
		cfg_phase_count       = 7'd1;
		next_slot             = '0;
		phase_ptr             = '0;
		plan_phase            = '0;
		send_burst            = 1'b0;
		take_burst            = 1'b0;
		for (int k = 0; k < TAPS_N; k++) begin
			hist_left[k]  = '0;
			hist_right[k] = '0;
		end
		for (int k = 0; k < COEF_SLOTS; k++) begin
			coef_mem[k]    = '0;
			coef_loaded[k] = 1'b0;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part under a phase count of zero, which behaves as a single phase.
		write_phase_count(7'd0);
		queue_item(ACT_LOAD, '0, '0, COEF_IDX_W'(0), COEF_MAX);
		queue_item(ACT_LOAD, '0, '0, COEF_IDX_W'(1), COEF_MIN);
		for (int k = 2; k < TAPS_N; k++)
			queue_item(ACT_LOAD, '0, '0, COEF_IDX_W'(k), '0);
		// Full-scale frames drive both channels into positive and negative saturation.
		queue_item(ACT_WRITE, SAMPLE_MAX, SAMPLE_MIN, '0, '0);
		queue_item(ACT_READ, '0, '0, '0, '0);
		queue_item(ACT_WRITE, SAMPLE_MIN, SAMPLE_MAX, '0, '0);
		queue_item(ACT_READ, '0, '0, '0, '0);
		// The unused code must change nothing.
		queue_item(ACT_UNUSED, SAMPLE_MAX, SAMPLE_MIN, '1, COEF_MIN);
		// Exact half-step sums: the positive tie rounds up, the negative one toward zero.
		queue_item(ACT_LOAD, '0, '0, COEF_IDX_W'(0), COEF_W'(2));
		queue_item(ACT_LOAD, '0, '0, COEF_IDX_W'(1), '0);
		queue_item(ACT_WRITE, 16'sd16384, -16'sd16384, '0, '0);
		queue_item(ACT_READ, '0, '0, '0, '0);
		settle();

		// Random parts: full table, clipped count, lowered counts, then random counts.
		for (int s = 0; s < SETTING_COUNT; s++) begin
			case (s)
				0: setting = 7'd64;
				1: setting = 7'd127;
				2: setting = 7'd3;
				3: setting = 7'd1;
				4: setting = 7'd2;
				default: setting = PCOUNT_W'($urandom_range(1, PHASES_N));
			endcase
			write_phase_count(setting);
			budget = budgets[s];
			made   = 0;
			while (made < budget) begin
				pick = $urandom_range(0, 99);
				if (pick < 40) begin
					queue_item(ACT_WRITE, rand_sample(), rand_sample(), COEF_IDX_W'($urandom),
						rand_coef());
					made++;
				end else if (pick < 75) begin
					queue_item(ACT_READ, rand_sample(), rand_sample(), COEF_IDX_W'($urandom),
						rand_coef());
					made++;
				end else if (pick < 93) begin
					// Loads land mostly in phases that are in use.
					if ($urandom_range(0, 3) == 0)
						queue_item(ACT_LOAD, rand_sample(), rand_sample(),
							COEF_IDX_W'($urandom), rand_coef());
					else
						queue_item(ACT_LOAD, rand_sample(), rand_sample(),
							COEF_IDX_W'($urandom_range(0, active_phases(setting) - 1)
							* TAPS_N + $urandom_range(0, TAPS_N - 1)), rand_coef());
					made++;
				end else begin
					queue_item(ACT_UNUSED, rand_sample(), rand_sample(), COEF_IDX_W'($urandom),
						rand_coef());
				end
			end
			settle();
		end

		$display("Run covered %0d write, %0d read, %0d load and %0d ignored transactions",
			writes_seen, reads_seen, loads_seen, ignored_seen);
		$display("under %0d phase count settings; %0d filtered frames compared.",
			settings_used, frames_checked);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
